// ===== src/tlsm_pkg.sv =====
// Shared types and constants for the tower light state monitor.
package tlsm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_RED_MODE      = 3'd0;
  localparam logic [2:0] REG_GREEN_MODE    = 3'd1;
  localparam logic [2:0] REG_YELLOW_MODE   = 3'd2;
  localparam logic [2:0] REG_PULSE_THRESH  = 3'd3;
  localparam logic [2:0] REG_QUALIFY_TICKS = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS    = 3'd5;
  localparam logic [2:0] REG_CHANGE_LIMIT  = 3'd6;

  // Yellow channel modes
  localparam logic [1:0] YMODE_STEADY = 2'd0;
  localparam logic [1:0] YMODE_FLASH  = 2'd1;
  localparam logic [1:0] YMODE_PULSE  = 2'd2;

  // Steady detector phases
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_QUALIFY = 2'd1;
  localparam logic [1:0] S_CONFIRM = 2'd2;
  localparam logic [1:0] S_RELEASE = 2'd3;

  // Flashing detector phases
  localparam logic [1:0] F_COUNT = 2'd0;
  localparam logic [1:0] F_ARM   = 2'd1;
  localparam logic [1:0] F_HOLD  = 2'd2;
  localparam logic [1:0] F_SPARE = 2'd3;

  // Reset values of the timing registers
  localparam logic [15:0] QUALIFY_RESET = 16'd5000;
  localparam logic [15:0] HOLD_RESET    = 16'd10000;
  localparam logic [3:0]  LIMIT_RESET   = 4'd8;

  // Microseconds per millisecond, at pulse limit width
  localparam int unsigned LIMIT_W = 26;
  localparam logic [LIMIT_W-1:0] US_PER_MS = 26'd1000;

  localparam int unsigned WIDTH_W = 22;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic               red_mode;
    logic               green_mode;
    logic [1:0]         yellow_mode;
    logic [LIMIT_W-1:0] pulse_limit_us;  // threshold in ms times 1000
    logic [15:0]        qualify_ticks;
    logic [15:0]        hold_ticks;
    logic [3:0]         change_limit;
  } cfg_t;

  // Per-channel detector selection
  typedef struct packed {
    logic steady;   // steady detector active
    logic flash;    // flashing detector active
    logic counts;   // yellow variant: events instead of a flag
  } ch_ctrl_t;

  // One registered input word
  typedef struct packed {
    logic               red_level;
    logic               green_level;
    logic               yellow_level;
    logic               pulse_done;
    logic [WIDTH_W-1:0] pulse_width_us;
  } in_word_t;

endpackage

// ===== src/tlsm_if.sv =====
// Channel interfaces: input words, result words and configuration writes.
interface tlsm_in_if;
  logic        valid;
  logic        ready;
  logic        red_level;
  logic        green_level;
  logic        yellow_level;
  logic        pulse_done;
  logic [21:0] pulse_width_us;

  modport source (output valid, red_level, green_level, yellow_level, pulse_done,
                  pulse_width_us, input ready);
  modport sink   (input valid, red_level, green_level, yellow_level, pulse_done,
                  pulse_width_us, output ready);
endinterface

interface tlsm_out_if;
  logic        valid;
  logic        ready;
  logic        red_alarm;
  logic        green_running;
  logic [15:0] yellow_count;

  modport source (output valid, red_alarm, green_running, yellow_count, input ready);
  modport sink   (input valid, red_alarm, green_running, yellow_count, output ready);
endinterface

interface tlsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tlsm_cfg.sv =====
// Configuration register file; the pulse threshold is stored scaled to microseconds.
module tlsm_cfg (
  input  logic           clk,
  input  logic           rst,
  tlsm_cfg_if.sink       cfg,
  output tlsm_pkg::cfg_t regs
);
  import tlsm_pkg::*;

  logic wr;

  // Writes are always taken
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  // Register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.red_mode       <= 1'b0;
      regs.green_mode     <= 1'b0;
      regs.yellow_mode    <= YMODE_STEADY;
      regs.pulse_limit_us <= '0;
      regs.qualify_ticks  <= QUALIFY_RESET;
      regs.hold_ticks     <= HOLD_RESET;
      regs.change_limit   <= LIMIT_RESET;
    end else if (wr) begin
      unique case (cfg.index)
        REG_RED_MODE:      regs.red_mode      <= cfg.data[0];
        REG_GREEN_MODE:    regs.green_mode    <= cfg.data[0];
        REG_YELLOW_MODE:   regs.yellow_mode   <= cfg.data[1:0];
        REG_PULSE_THRESH:  regs.pulse_limit_us <= LIMIT_W'(cfg.data) * US_PER_MS;
        REG_QUALIFY_TICKS: regs.qualify_ticks <= cfg.data;
        REG_HOLD_TICKS:    regs.hold_ticks    <= cfg.data;
        REG_CHANGE_LIMIT:  regs.change_limit  <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tlsm_channel.sv =====
// One lamp channel: steady and flashing detectors sharing a countdown timer.
module tlsm_channel (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               level,
  input  tlsm_pkg::ch_ctrl_t ctrl,
  input  tlsm_pkg::cfg_t     regs,
  output logic               flag_next,
  output logic               event_hit
);
  import tlsm_pkg::*;

  logic [1:0]  steady_phase, steady_phase_next;
  logic [1:0]  flash_phase, flash_phase_next;
  logic        previous_level, previous_level_next;
  logic [3:0]  change_tally, change_tally_next;
  logic [15:0] countdown, countdown_next, countdown_dec;
  logic        countdown_armed, countdown_armed_next;
  logic        flag;
  logic        expired;

  // Armed timer runs down on every tick and stops at zero
  always_comb begin
    countdown_dec = countdown;
    if (countdown_armed && (countdown != 16'd0)) countdown_dec = countdown - 16'd1;
  end
  assign expired = countdown_armed && (countdown_dec == 16'd0);

  // Detector update for one tick
  always_comb begin
    steady_phase_next    = steady_phase;
    flash_phase_next     = flash_phase;
    previous_level_next  = previous_level;
    change_tally_next    = change_tally;
    countdown_next       = countdown_dec;
    countdown_armed_next = countdown_armed;
    flag_next            = flag;
    event_hit            = 1'b0;

    if (ctrl.steady) begin
      unique case (steady_phase)
        S_IDLE: begin
          if (level) begin
            countdown_next       = regs.qualify_ticks;
            countdown_armed_next = 1'b1;
            steady_phase_next    = S_QUALIFY;
          end else if (!ctrl.counts) begin
            flag_next = 1'b0;
          end
        end
        S_QUALIFY: begin
          if (expired) begin
            countdown_armed_next = 1'b0;
            steady_phase_next    = S_CONFIRM;
          end else if (!level) begin
            steady_phase_next = S_IDLE;
          end
        end
        S_CONFIRM: begin
          if (ctrl.counts) begin
            event_hit         = level;
            steady_phase_next = S_RELEASE;
          end else begin
            flag_next         = level;
            steady_phase_next = S_IDLE;
          end
        end
        default: begin
          // yellow waits for the lamp to go dark, others just return
          if (!ctrl.counts || !level) steady_phase_next = S_IDLE;
        end
      endcase
    end else if (ctrl.flash) begin
      unique case (flash_phase)
        F_COUNT: begin
          if (previous_level != level) begin
            if (change_tally >= regs.change_limit) begin
              change_tally_next = 4'd0;
              if (ctrl.counts) event_hit = 1'b1;
              else flag_next = 1'b1;
              flash_phase_next = F_ARM;
            end else begin
              change_tally_next = change_tally + 4'd1;
            end
            previous_level_next = level;
          end
        end
        F_ARM: begin
          countdown_next       = regs.hold_ticks;
          countdown_armed_next = 1'b1;
          flash_phase_next     = F_HOLD;
        end
        F_HOLD: begin
          if (expired) begin
            countdown_armed_next = 1'b0;
            flash_phase_next     = F_COUNT;
            if (!ctrl.counts) flag_next = 1'b0;
          end else if (level) begin
            flash_phase_next = F_ARM;
          end
        end
        default: flash_phase_next = F_COUNT;
      endcase
    end
  end

  // State registers, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      steady_phase    <= S_IDLE;
      flash_phase     <= F_COUNT;
      previous_level  <= 1'b0;
      change_tally    <= 4'd0;
      countdown       <= 16'd0;
      countdown_armed <= 1'b0;
      flag            <= 1'b0;
    end else if (tick) begin
      steady_phase    <= steady_phase_next;
      flash_phase     <= flash_phase_next;
      previous_level  <= previous_level_next;
      change_tally    <= change_tally_next;
      countdown       <= countdown_next;
      countdown_armed <= countdown_armed_next;
      flag            <= flag_next;
    end
  end

endmodule

// ===== src/tower_light_state_monitor.sv =====
// Top level of the tower light state monitor.
//
// Usage: every word on item_in is one 1 ms tick carrying the sampled red,
// green and yellow lamp levels plus an optional finished pulse capture.
// For every input word exactly one word leaves on result_out with the red
// alarm flag, the green running flag and the yellow event count as they
// stand after that tick.
// Configuration is written on cfg (index 0..6, ready always high) while the
// block holds no word; an index past the list is ignored.
// Timing: a word is registered in the input register and, once the result
// register is free, is folded into the channel state and the result register,
// where its result word then waits for result_out.ready. One word per cycle is
// sustained while the receiver takes every result; the rate is set by the
// combinational state update of the three channel detectors.
// Reset (rst, synchronous) clears all detector state, flags, the event
// count, empties both pipeline registers and loads the register defaults.
// When the receiver stalls the result register holds its word; one more
// input word is taken into the input register, after which item_in.ready
// follows result_out.ready.
module tower_light_state_monitor (
  input  logic       clk,
  input  logic       rst,
  tlsm_in_if.sink    item_in,
  tlsm_out_if.source result_out,
  tlsm_cfg_if.sink   cfg
);
  import tlsm_pkg::*;

  cfg_t       regs;
  in_word_t   in_q;
  logic       in_q_valid;
  logic       advance;
  ch_ctrl_t   red_ctrl, green_ctrl, yellow_ctrl;
  logic       red_flag_next, green_flag_next, yellow_flag_next;
  logic       red_event, green_event, yellow_event;
  logic       pulse_event;
  logic [15:0] event_total, event_total_next;
  logic       result_valid;

  tlsm_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Handshake: the state step fires when the input register holds a word and the result register is free or draining
  assign advance       = in_q_valid && (!result_valid || result_out.ready);
  assign item_in.ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_q_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_q.red_level      <= item_in.red_level;
      in_q.green_level    <= item_in.green_level;
      in_q.yellow_level   <= item_in.yellow_level;
      in_q.pulse_done     <= item_in.pulse_done;
      in_q.pulse_width_us <= item_in.pulse_width_us;
    end
  end

  // Detector selection per channel
  always_comb begin
    red_ctrl.steady    = !regs.red_mode;
    red_ctrl.flash     = regs.red_mode;
    red_ctrl.counts    = 1'b0;
    green_ctrl.steady  = !regs.green_mode;
    green_ctrl.flash   = regs.green_mode;
    green_ctrl.counts  = 1'b0;
    yellow_ctrl.steady = (regs.yellow_mode == YMODE_STEADY);
    yellow_ctrl.flash  = (regs.yellow_mode == YMODE_FLASH);
    yellow_ctrl.counts = 1'b1;
  end

  tlsm_channel u_red (
    .clk       (clk),
    .rst       (rst),
    .tick      (advance),
    .level     (in_q.red_level),
    .ctrl      (red_ctrl),
    .regs      (regs),
    .flag_next (red_flag_next),
    .event_hit (red_event)
  );

  tlsm_channel u_green (
    .clk       (clk),
    .rst       (rst),
    .tick      (advance),
    .level     (in_q.green_level),
    .ctrl      (green_ctrl),
    .regs      (regs),
    .flag_next (green_flag_next),
    .event_hit (green_event)
  );

  tlsm_channel u_yellow (
    .clk       (clk),
    .rst       (rst),
    .tick      (advance),
    .level     (in_q.yellow_level),
    .ctrl      (yellow_ctrl),
    .regs      (regs),
    .flag_next (yellow_flag_next),
    .event_hit (yellow_event)
  );

  // Pulse mode: width/1000 >= threshold is width >= threshold*1000
  assign pulse_event = (regs.yellow_mode == YMODE_PULSE) && in_q.pulse_done &&
                       (LIMIT_W'(in_q.pulse_width_us) >= regs.pulse_limit_us);

  // Event counter, wraps at 16 bits; red/green never count and the
  // yellow flag is unused
  assign event_total_next = event_total +
                            16'((yellow_event || pulse_event) &&
                                !(red_event && green_event && yellow_flag_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      event_total <= 16'd0;
    end else if (advance) begin
      event_total <= event_total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_out.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_out.red_alarm     <= red_flag_next;
      result_out.green_running <= green_flag_next;
      result_out.yellow_count  <= event_total_next;
    end
  end

  assign result_out.valid = result_valid;

endmodule

// ===== src/tlsm_checker.sv =====
// Port-level checks for the tower light state monitor, bound to the top level.
module tlsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        red_alarm,
  input logic        green_running,
  input logic [15:0] yellow_count
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_alarm) &&
      $stable(green_running) && $stable(yellow_count))
    else $error("result word changed while stalled");

  // Reset empties both pipeline registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // Word taken behind a stalled result fills the input register; input ready then follows output ready
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_valid && in_ready |=> in_ready == out_ready)
    else $error("input ready does not follow output ready when full");

endmodule

bind tower_light_state_monitor tlsm_checker u_tlsm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item_in.valid),
  .in_ready      (item_in.ready),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .red_alarm     (result_out.red_alarm),
  .green_running (result_out.green_running),
  .yellow_count  (result_out.yellow_count)
);
